// ----- hdl/telnet_rx_parser_option_negotiator_core_macros.svh -----
// Assertion macros shared by the telnet receive parser queue and negotiator
`ifndef TELNET_RX_PARSER_OPTION_NEGOTIATOR_CORE_MACROS_SVH
`define TELNET_RX_PARSER_OPTION_NEGOTIATOR_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define TNRX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger
`define TNRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tnrx_pkg.sv -----
// Shared types and constants for the telnet receive parser
package tnrx_pkg;

  // Protocol bytes
  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_SE   = 8'hF0;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_IAC  = 8'hFF;

  // Option codes with special handling
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_STATUS = 8'd6;
  localparam logic [7:0] OPT_NAWS   = 8'd31;

  // Command queue sizing
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  // Result kinds on the output
  localparam logic OUT_DATA  = 1'b0;
  localparam logic OUT_REPLY = 1'b1;

  // Work item handed from the parser to the negotiator
  typedef enum logic [2:0] {
    CMD_DATA = 3'd0,
    CMD_WILL = 3'd1,
    CMD_WONT = 3'd2,
    CMD_DO   = 3'd3,
    CMD_DONT = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;
  } cmd_t;

  // Command queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- hdl/tnrx_front.sv -----
// Byte parser: tracks the stream state and classifies each byte
module tnrx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  input  tnrx_pkg::qstat_t    qstat,
  output logic                cmd_wr,
  output tnrx_pkg::cmd_t      cmd
);

  typedef enum logic [9:0] {
    ST_NORMAL = 10'b0000000001,
    ST_CR     = 10'b0000000010,
    ST_IAC    = 10'b0000000100,
    ST_WILL   = 10'b0000001000,
    ST_WONT   = 10'b0000010000,
    ST_DO     = 10'b0000100000,
    ST_DONT   = 10'b0001000000,
    ST_SB     = 10'b0010000000,
    ST_SB_CR  = 10'b0100000000,
    ST_SB_IAC = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;
  logic   accept;

  assign accept = push & ~qstat.full;

  // Decode the next state and whether this byte yields work
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    cmd.kind   = tnrx_pkg::CMD_DATA;
    cmd.value  = rx_byte;
    case (state)
      ST_CR: begin
        if (rx_byte == tnrx_pkg::B_NUL) begin
          state_next = ST_NORMAL;
          emit       = 1'b1;
          cmd.value  = tnrx_pkg::B_CR;
        end else if (rx_byte == tnrx_pkg::B_IAC) begin
          state_next = ST_IAC;
        end else if (rx_byte == tnrx_pkg::B_CR) begin
          state_next = ST_CR;
        end else begin
          state_next = ST_NORMAL;
          emit       = 1'b1;
        end
      end
      ST_IAC: begin
        case (rx_byte)
          tnrx_pkg::B_IAC: begin
            state_next = ST_NORMAL;
            emit       = 1'b1;
          end
          tnrx_pkg::B_SB:   state_next = ST_SB;
          tnrx_pkg::B_WILL: state_next = ST_WILL;
          tnrx_pkg::B_WONT: state_next = ST_WONT;
          tnrx_pkg::B_DO:   state_next = ST_DO;
          tnrx_pkg::B_DONT: state_next = ST_DONT;
          default:          state_next = ST_NORMAL;
        endcase
      end
      ST_WILL: begin
        state_next = ST_NORMAL;
        emit       = 1'b1;
        cmd.kind   = tnrx_pkg::CMD_WILL;
      end
      ST_WONT: begin
        state_next = ST_NORMAL;
        emit       = 1'b1;
        cmd.kind   = tnrx_pkg::CMD_WONT;
      end
      ST_DO: begin
        state_next = ST_NORMAL;
        emit       = 1'b1;
        cmd.kind   = tnrx_pkg::CMD_DO;
      end
      ST_DONT: begin
        state_next = ST_NORMAL;
        emit       = 1'b1;
        cmd.kind   = tnrx_pkg::CMD_DONT;
      end
      ST_SB: begin
        if (rx_byte == tnrx_pkg::B_IAC) begin
          state_next = ST_SB_IAC;
        end else if (rx_byte == tnrx_pkg::B_CR) begin
          state_next = ST_SB_CR;
        end else begin
          emit = 1'b1;
        end
      end
      ST_SB_CR: begin
        if (rx_byte inside {tnrx_pkg::B_LF, tnrx_pkg::B_NUL}) begin
          state_next = ST_SB;
        end else if (rx_byte == tnrx_pkg::B_IAC) begin
          state_next = ST_SB_IAC;
        end else begin
          state_next = ST_SB;
          emit       = 1'b1;
        end
      end
      ST_SB_IAC: begin
        if (rx_byte == tnrx_pkg::B_SE) begin
          state_next = ST_NORMAL;
        end else if (rx_byte != tnrx_pkg::B_IAC) begin
          state_next = ST_SB;
        end
      end
      default: begin
        // Plain data, and any code outside the state set
        if (rx_byte == tnrx_pkg::B_IAC) begin
          state_next = ST_IAC;
        end else if (rx_byte == tnrx_pkg::B_CR) begin
          state_next = ST_CR;
        end else begin
          state_next = ST_NORMAL;
          emit       = 1'b1;
        end
      end
    endcase
  end

  assign cmd_wr = accept & emit;

  // Advance the parser on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_NORMAL;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/tnrx_cmdq.sv -----
// Two-entry command queue between parser and negotiator
`include "telnet_rx_parser_option_negotiator_core_macros.svh"

module tnrx_cmdq (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  tnrx_pkg::cmd_t    wdata,
  input  logic              rd,
  output tnrx_pkg::cmd_t    rdata,
  output tnrx_pkg::qstat_t  stat
);

  tnrx_pkg::cmd_t                    mem [tnrx_pkg::CMDQ_DEPTH];
  logic [tnrx_pkg::CMDQ_AW-1:0]      wptr;
  logic [tnrx_pkg::CMDQ_AW-1:0]      rptr;
  logic [tnrx_pkg::CMDQ_CW-1:0]      count;

  assign stat.full  = (count == tnrx_pkg::CMDQ_CW'(tnrx_pkg::CMDQ_DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rptr];

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `TNRX_ASSERT_NOW(a_no_overflow, wr && stat.full, rd, "command written into a full queue")
  `TNRX_ASSERT_NOW(a_no_underflow, rd, !stat.empty, "command read from an empty queue")
  `TNRX_ASSERT_NOW(a_count_range, 1'b1, count <= tnrx_pkg::CMDQ_CW'(tnrx_pkg::CMDQ_DEPTH), "queue count out of range")

endmodule

// ----- hdl/tnrx_back.sv -----
// Option negotiator: answers option commands, passes data bytes and registers each result
`include "telnet_rx_parser_option_negotiator_core_macros.svh"

module tnrx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              refuse_remote_echo_we,
  input  logic              refuse_remote_echo,
  input  tnrx_pkg::qstat_t  qstat,
  input  tnrx_pkg::cmd_t    cmd,
  output logic              cmd_rd,
  output logic              empty,
  input  logic              pop,
  output logic              out_kind,
  output logic [7:0]        data_byte,
  output logic [7:0]        reply_command,
  output logic [7:0]        reply_option,
  output logic              echo_flag,
  output logic              naws_flag,
  output logic              resize_write,
  output logic              resize_value
);

  logic       refuse_echo;
  logic       echo_on;
  logic       naws_on;
  logic       echo_next;
  logic       naws_next;
  logic       out_valid;
  logic       load;
  logic       on;
  logic       refused;
  logic       r_kind;
  logic [7:0] r_data;
  logic [7:0] r_cmd;
  logic [7:0] r_opt;
  logic       r_rw;
  logic       r_rv;

  assign load   = ~qstat.empty & (~out_valid | pop);
  assign cmd_rd = load;
  assign empty  = ~out_valid;

  // Hold the echo policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      refuse_echo <= 1'b0;
    end else if (refuse_remote_echo_we) begin
      refuse_echo <= refuse_remote_echo;
    end
  end

  // Build the result for the command at the queue head
  always_comb begin
    echo_next = echo_on;
    naws_next = naws_on;
    on        = (cmd.kind == tnrx_pkg::CMD_WILL) || (cmd.kind == tnrx_pkg::CMD_DO);
    refused   = cmd.value inside {8'd5, 8'd24, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd39};
    r_kind    = tnrx_pkg::OUT_REPLY;
    r_data    = 8'd0;
    r_cmd     = 8'd0;
    r_opt     = cmd.value;
    r_rw      = 1'b0;
    r_rv      = 1'b0;
    case (cmd.kind)
      tnrx_pkg::CMD_WILL, tnrx_pkg::CMD_WONT: begin
        r_cmd = tnrx_pkg::B_DONT;
        if (!refused) begin
          case (cmd.value)
            tnrx_pkg::OPT_BINARY, tnrx_pkg::OPT_SGA, tnrx_pkg::OPT_STATUS: begin
              r_cmd = on ? tnrx_pkg::B_DO : tnrx_pkg::B_DONT;
            end
            tnrx_pkg::OPT_ECHO: begin
              if (!refuse_echo) begin
                echo_next = on;
                r_cmd     = on ? tnrx_pkg::B_DO : tnrx_pkg::B_DONT;
              end
            end
            tnrx_pkg::OPT_NAWS: begin
              naws_next = on;
              r_cmd     = on ? tnrx_pkg::B_DO : tnrx_pkg::B_DONT;
              r_rw      = 1'b1;
              r_rv      = on;
            end
            default: r_cmd = tnrx_pkg::B_DONT;
          endcase
        end
      end
      tnrx_pkg::CMD_DO, tnrx_pkg::CMD_DONT: begin
        r_cmd = tnrx_pkg::B_WONT;
        if (!refused) begin
          case (cmd.value)
            tnrx_pkg::OPT_BINARY, tnrx_pkg::OPT_STATUS: begin
              r_cmd = on ? tnrx_pkg::B_WILL : tnrx_pkg::B_WONT;
            end
            tnrx_pkg::OPT_SGA: r_cmd = tnrx_pkg::B_WILL;
            tnrx_pkg::OPT_NAWS: begin
              naws_next = on;
              r_cmd     = on ? tnrx_pkg::B_WILL : tnrx_pkg::B_WONT;
              r_rw      = 1'b1;
              r_rv      = on;
            end
            default: r_cmd = tnrx_pkg::B_WONT;
          endcase
        end
      end
      default: begin
        // Data byte for local output
        r_kind = tnrx_pkg::OUT_DATA;
        r_data = cmd.value;
        r_opt  = 8'd0;
      end
    endcase
  end

  // Update negotiated flags and the result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_on   <= 1'b0;
      naws_on   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        echo_on   <= echo_next;
        naws_on   <= naws_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind      <= r_kind;
      data_byte     <= r_data;
      reply_command <= r_cmd;
      reply_option  <= r_opt;
      echo_flag     <= echo_next;
      naws_flag     <= naws_next;
      resize_write  <= r_rw;
      resize_value  <= r_rv;
    end
  end

  `TNRX_ASSERT_NOW(a_flags_match, out_valid, (echo_flag == echo_on) && (naws_flag == naws_on), "result flags differ from negotiated state")
  `TNRX_ASSERT_NOW(a_resize_naws, out_valid && resize_write, out_kind && (reply_option == tnrx_pkg::OPT_NAWS), "resize write on a non-NAWS result")
  `TNRX_ASSERT_NEXT(a_load_fills, load, out_valid, "loaded result not presented")

endmodule

// ----- hdl/telnet_rx_parser_option_negotiator_core.sv -----
// Top level of the telnet receive parser and option negotiator
//
//   channel   direction  handshake              payload
//   input     in         push / full            rx_byte
//   result    out        empty / pop            out_kind, data_byte, reply_command,
//                                               reply_option, echo_flag, naws_flag,
//                                               resize_write, resize_value
//   config    in         refuse_remote_echo_we  refuse_remote_echo
//
// One byte is accepted per cycle while full is low; a result passes through the
// command queue register, then the result register.
// The parser and the negotiator are joined by a two-entry command queue;
// full follows that queue, so it rises only when the result is held by pop low.
// rst is synchronous and clears parser state, flags, queue and result valid.
// Bytes that end in no result (command prefixes, CR pending) pass the queue by.
module telnet_rx_parser_option_negotiator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind,
  output logic [7:0] data_byte,
  output logic [7:0] reply_command,
  output logic [7:0] reply_option,
  output logic       echo_flag,
  output logic       naws_flag,
  output logic       resize_write,
  output logic       resize_value,
  input  logic       refuse_remote_echo_we,
  input  logic       refuse_remote_echo
);

  tnrx_pkg::qstat_t qstat;
  tnrx_pkg::cmd_t   wcmd;
  tnrx_pkg::cmd_t   rcmd;
  logic             cmd_wr;
  logic             cmd_rd;

  assign full = qstat.full;

  // Parse and classify incoming bytes
  tnrx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .qstat   (qstat),
    .cmd_wr  (cmd_wr),
    .cmd     (wcmd)
  );

  // Decouple parser from negotiator
  tnrx_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_wr),
    .wdata (wcmd),
    .rd    (cmd_rd),
    .rdata (rcmd),
    .stat  (qstat)
  );

  // Answer options and present results
  tnrx_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .refuse_remote_echo_we (refuse_remote_echo_we),
    .refuse_remote_echo    (refuse_remote_echo),
    .qstat                 (qstat),
    .cmd                   (rcmd),
    .cmd_rd                (cmd_rd),
    .empty                 (empty),
    .pop                   (pop),
    .out_kind              (out_kind),
    .data_byte             (data_byte),
    .reply_command         (reply_command),
    .reply_option          (reply_option),
    .echo_flag             (echo_flag),
    .naws_flag             (naws_flag),
    .resize_write          (resize_write),
    .resize_value          (resize_value)
  );

endmodule
